// ----- rtl/core/ubd_pkg.sv -----
// Shared types and constants for the UART baud divisor calculator.
// No dependencies; every other file in rtl/core imports this package.
package ubd_pkg;

  localparam int CLK_W     = 28;             // clock_hz width
  localparam int BAUD_W    = 24;             // baud_rate width
  localparam int PROD_W    = 35;             // 100 * clock_hz
  localparam int DIVD_W    = 32;             // (100 * clock_hz) >> 4 or >> 3
  localparam int MANTQ_W   = 25;             // floor(div100 / 100)
  localparam int MANTC_W   = MANTQ_W + 1;    // mantissa after carry
  localparam int REM_W     = 7;              // div100 mod 100
  localparam int RECIP_W   = 31;
  localparam int RPROD_W   = DIVD_W + RECIP_W;
  localparam int RECIP_SH  = 37;
  localparam int FRX_W     = 11;             // rem * steps + 50
  localparam int FRECIP_W  = 12;
  localparam int FPROD_W   = FRX_W + FRECIP_W;
  localparam int FRAC_SH   = 18;
  localparam int STEP_W    = 5;
  localparam int MANT_W    = 12;             // mantissa field width
  localparam int FRAC_W    = 4;
  localparam int WORD_W    = 16;
  localparam int STAT_W    = 2;
  localparam int MANT_BITS = 12;             // divider mantissa width; mantissa saturates at 4095

  localparam logic [PROD_W-1:0]   SCALE_100   = PROD_W'(100);
  localparam logic [RECIP_W-1:0]  RECIP_100   = RECIP_W'(1374389535); // ceil(2^37/100)
  localparam logic [FRECIP_W-1:0] FRECIP_100  = FRECIP_W'(2622);     // ceil(2^18/100)
  localparam logic [FRX_W-1:0]    ROUND_HALF  = FRX_W'(50);
  localparam logic [DIVD_W-1:0]   HUNDRED     = DIVD_W'(100);
  localparam logic [STEP_W-1:0]   STEPS_16X   = STEP_W'(16);
  localparam logic [STEP_W-1:0]   STEPS_8X    = STEP_W'(8);
  localparam logic [MANTC_W-1:0]  MANT_LIMIT  = MANTC_W'((32'd1 << MANT_BITS) - 32'd1);

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_BAUD = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  // One row of the divider chain: partial remainder plus dividend/quotient shifter.
  typedef struct packed {
    logic              vld;
    logic [BAUD_W-1:0] rem;
    logic [DIVD_W-1:0] quo;
    logic [BAUD_W-1:0] baud;
    logic              over8;
    logic              zero;
  } div_row_t;

  typedef struct packed {
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction;
    logic [WORD_W-1:0] register_word;
    status_t           status;
  } res_t;

endpackage

// ----- rtl/core/ubd_if.sv -----
// Valid/ready channel interfaces for the baud divisor calculator.
// Depends on ubd_pkg for field widths.
interface ubd_in_if import ubd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] baud_rate;
  logic              oversample_by_8;

  modport source (output valid, clock_hz, baud_rate, oversample_by_8, input ready);
  modport sink   (input valid, clock_hz, baud_rate, oversample_by_8, output ready);
endinterface

interface ubd_out_if import ubd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MANT_W-1:0] mantissa;
  logic [FRAC_W-1:0] fraction;
  logic [WORD_W-1:0] register_word;
  logic [STAT_W-1:0] status;

  modport source (output valid, mantissa, fraction, register_word, status, input ready);
  modport sink   (input valid, mantissa, fraction, register_word, status, output ready);
endinterface

// ----- rtl/core/ubd_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per word.
// Depends on ubd_pkg (div_row_t).
module ubd_div_cell import ubd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_row_t row_i,
  output div_row_t row_o
);

  logic [BAUD_W:0] trial;
  logic [BAUD_W:0] diff;
  logic            ge;
  div_row_t        row_nxt;
  div_row_t        row_r;

  always_comb begin
    trial       = {row_i.rem, row_i.quo[DIVD_W-1]};
    diff        = trial - {1'b0, row_i.baud};
    ge          = (trial >= {1'b0, row_i.baud});
    row_nxt     = row_i;
    row_nxt.rem = ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
    row_nxt.quo = {row_i.quo[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r.vld <= 1'b0;
    end else if (en) begin
      row_r <= row_nxt;
    end
  end

  assign row_o = row_r;

endmodule

// ----- rtl/core/ubd_post.sv -----
// Post-divide stages: split div100 into mantissa and rounded fraction,
// carry, saturate, zero-baud override and pack. Depends on ubd_pkg.
module ubd_post import ubd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_row_t row_i,
  output logic     vld_o,
  output res_t     res_o
);

  // stage 1: div100 and its reciprocal product
  logic               p1_vld_r;
  logic [DIVD_W-1:0]  p1_div_r;
  logic [RPROD_W-1:0] p1_prod_r;
  logic               p1_over8_r;
  logic               p1_zero_r;
  // stage 2: mantissa and remainder
  logic               p2_vld_r;
  logic [MANTQ_W-1:0] p2_mant_r;
  logic [REM_W-1:0]   p2_rem_r;
  logic               p2_over8_r;
  logic               p2_zero_r;

  logic [MANTQ_W-1:0] mant_q;
  logic [DIVD_W-1:0]  rem_full;
  logic [STEP_W-1:0]  steps;
  logic [FRX_W-1:0]   frx;
  logic [FPROD_W-1:0] fprod;
  logic [STEP_W-1:0]  frac_raw;
  logic               carry;
  logic [MANTC_W-1:0] mant_c;
  logic               sat;
  logic [MANTC_W-1:0] mant_sel;
  logic [FRAC_W-1:0]  frac_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= row_i.vld;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_div_r   <= row_i.quo;
      p1_prod_r  <= RPROD_W'(row_i.quo) * RPROD_W'(RECIP_100);
      p1_over8_r <= row_i.over8;
      p1_zero_r  <= row_i.zero;
      p2_mant_r  <= mant_q;
      p2_rem_r   <= rem_full[REM_W-1:0];
      p2_over8_r <= p1_over8_r;
      p2_zero_r  <= p1_zero_r;
    end
  end

  always_comb begin
    mant_q   = p1_prod_r[RECIP_SH +: MANTQ_W];
    rem_full = p1_div_r - DIVD_W'(DIVD_W'(mant_q) * HUNDRED);
  end

  always_comb begin
    steps    = p2_over8_r ? STEPS_8X : STEPS_16X;
    frx      = (p2_over8_r ? {1'b0, p2_rem_r, 3'b000} : {p2_rem_r, 4'b0000}) + ROUND_HALF;
    fprod    = FPROD_W'(frx) * FPROD_W'(FRECIP_100);
    frac_raw = fprod[FRAC_SH +: STEP_W];
    carry    = (frac_raw == steps);
    mant_c   = {1'b0, p2_mant_r} + MANTC_W'(carry);
    sat      = (mant_c > MANT_LIMIT);
    mant_sel = sat ? MANT_LIMIT : mant_c;
    if (sat) begin
      frac_sel = FRAC_W'(steps - STEP_W'(1));
    end else if (carry) begin
      frac_sel = '0;
    end else begin
      frac_sel = frac_raw[FRAC_W-1:0];
    end

    if (p2_zero_r) begin
      res_o.mantissa      = '0;
      res_o.fraction      = '0;
      res_o.register_word = '0;
      res_o.status        = ST_ZERO_BAUD;
    end else begin
      res_o.mantissa      = mant_sel[MANT_W-1:0];
      res_o.fraction      = frac_sel;
      res_o.register_word = {mant_sel[MANT_W-1:0], frac_sel};
      res_o.status        = sat ? ST_SATURATED : ST_OK;
    end
  end

  assign vld_o = p2_vld_r;

endmodule

// ----- rtl/core/uart_baud_divisor_calc_core.sv -----
// UART baud divisor calculator, top level: prescale, divider cell chain, post stages.
// Depends on ubd_pkg, ubd_if, ubd_div_cell, ubd_post.
// Registers from input to output: 1 prescale register, 32 division cells, 2 post stages,
// 1 output register. Throughput: one word per cycle while the pipeline is not frozen.
// The whole pipeline freezes only when the output register holds an untaken word and
// the last post stage is full; while that stage holds a bubble the chain keeps moving.
// Reset (synchronous, rst_n low) clears every valid bit; payloads are not reset.
module uart_baud_divisor_calc_core import ubd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ubd_in_if.sink    in_ch,
  ubd_out_if.source out_ch
);

  // Divider rows: rows[0] is the prescale register, rows[i+1] the output of cell i.
  div_row_t            rows [0:DIVD_W];
  div_row_t            prep_nxt;
  div_row_t            prep_r;
  logic [PROD_W-1:0]   prod100;
  logic                en;
  logic                post_vld;
  res_t                post_res;
  logic                out_valid_r;
  logic                out_valid_nxt;
  res_t                out_r;

  // Global advance. Held back only when the result register cannot drain and a
  // new word is arriving behind it.
  assign en          = !(out_valid_r && !out_ch.ready && post_vld);
  assign in_ch.ready = en;

  // Prescale: div100 = floor(100*clk / (D*baud)) with D = 16 or 8, and since D
  // is a power of two the shift (4 or 3) moves ahead of the division.
  always_comb begin
    prod100        = PROD_W'(in_ch.clock_hz) * SCALE_100;
    prep_nxt.vld   = in_ch.valid;
    prep_nxt.rem   = '0;
    prep_nxt.quo   = in_ch.oversample_by_8 ? prod100[PROD_W-1:3]
                                           : {1'b0, prod100[PROD_W-1:4]};
    prep_nxt.baud  = in_ch.baud_rate;
    prep_nxt.over8 = in_ch.oversample_by_8;
    prep_nxt.zero  = (in_ch.baud_rate == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign rows[0] = prep_r;

  // One cell per quotient bit, MSB first. A zero divisor runs through harmlessly;
  // the post stage overrides that result.
  for (genvar gi = 0; gi < DIVD_W; gi++) begin : g_cell
    ubd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .row_i (rows[gi]),
      .row_o (rows[gi+1])
    );
  end

  ubd_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .row_i (rows[DIVD_W]),
    .vld_o (post_vld),
    .res_o (post_res)
  );

  // Output register: loads on advance when a word arrives, clears when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en && post_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && post_vld) begin
      out_r <= post_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mantissa      = out_r.mantissa;
  assign out_ch.fraction      = out_r.fraction;
  assign out_ch.register_word = out_r.register_word;
  assign out_ch.status        = out_r.status;

endmodule

// ----- rtl/core/ubd_checker.sv -----
// Port-level checks for the baud divisor calculator, bound to the top level.
// Depends on ubd_pkg and uart_baud_divisor_calc_core.
module ubd_checker import ubd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MANT_W-1:0] mantissa,
  input logic [FRAC_W-1:0] fraction,
  input logic [WORD_W-1:0] register_word,
  input logic [STAT_W-1:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(register_word) && $stable(status))
    else $error("result word changed while stalled");

  a_word_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> register_word == {mantissa, fraction})
    else $error("register word does not match mantissa and fraction");

  a_zero_baud: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_ZERO_BAUD |-> register_word == '0)
    else $error("zero baud result not cleared");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SATURATED |-> mantissa == MANT_LIMIT[MANT_W-1:0]
                                            && fraction[2:0] == 3'b111)
    else $error("saturated result not at full scale");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind uart_baud_divisor_calc_core ubd_checker u_ubd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .mantissa      (out_ch.mantissa),
  .fraction      (out_ch.fraction),
  .register_word (out_ch.register_word),
  .status        (out_ch.status)
);

// ----- tb/sv/ubd_divisor_checker.sv -----
// Checker for the baud divisor calculator: watches both channels, predicts each result
// word and compares it field by field. Depends on ubd_pkg and ubd_if.
module ubd_divisor_checker import ubd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ubd_in_if    in_mon,
  ubd_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  res_t expected_divisors[$];

  // Divider scaled by 100, split into mantissa and rounded fraction, with carry and
  // saturation. Kept at 64 bits so 100 * clock_hz never wraps.
  function automatic res_t predict_divisor(input logic [CLK_W-1:0]  clock_hz,
                                           input logic [BAUD_W-1:0] baud_rate,
                                           input logic              over8);
    logic [63:0] steps, div100, mant, rem, frac, ceiling;
    res_t r;
    r = '0;
    r.status = ST_OK;
    if (baud_rate == '0) begin
      r.status = ST_ZERO_BAUD;
      return r;
    end
    steps   = over8 ? 64'd8 : 64'd16;
    ceiling = (64'd1 << MANT_BITS) - 64'd1;
    div100  = (64'd100 * clock_hz) / (steps * baud_rate);
    mant    = div100 / 64'd100;
    rem     = div100 - mant * 64'd100;
    frac    = (rem * steps + 64'd50) / 64'd100;
    if (frac == steps) begin
      mant = mant + 64'd1;
      frac = 64'd0;
    end
    if (mant > ceiling) begin
      mant     = ceiling;
      frac     = steps - 64'd1;
      r.status = ST_SATURATED;
    end
    r.mantissa      = mant[MANT_W-1:0];
    r.fraction      = frac[FRAC_W-1:0];
    r.register_word = WORD_W'((mant << 4) | frac);
    return r;
  endfunction

  function automatic int field_errors(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    res_t exp_r;
    int   errs;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_divisors.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %0d/%0d/%0h/%0d",
                   $time, out_mon.mantissa, out_mon.fraction, out_mon.register_word,
                   out_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_divisors.pop_front();
          errs  = field_errors("mantissa", exp_r.mantissa, out_mon.mantissa)
                + field_errors("fraction", exp_r.fraction, out_mon.fraction)
                + field_errors("register_word", exp_r.register_word, out_mon.register_word)
                + field_errors("status", exp_r.status, out_mon.status);
          if (errs != 0) fail_count <= fail_count + 1;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_divisors.push_back(predict_divisor(in_mon.clock_hz, in_mon.baud_rate,
                                                    in_mon.oversample_by_8));
      end
      pending <= expected_divisors.size();
    end
  end

endmodule

// ----- tb/sv/tb_uart_baud_divisor_calc_core.sv -----
// Testbench top for uart_baud_divisor_calc_core: clock, reset, stimulus and verdict.
// Depends on ubd_pkg, ubd_if, ubd_divisor_checker and the core RTL.
module tb_uart_baud_divisor_calc_core;
  import ubd_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 40;    // extra wait after the checker's queue empties

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_STALLS} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  ubd_in_if  in_ch ();
  ubd_out_if out_ch ();

  uart_baud_divisor_calc_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ubd_divisor_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drive one word at the falling edge and hold it until the core takes it.
  // Valid stays high on return, so back-to-back words need no re-raise.
  task automatic send_word(input logic [CLK_W-1:0] clock_hz,
                           input logic [BAUD_W-1:0] baud_rate,
                           input logic over8);
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.clock_hz        <= clock_hz;
    in_ch.baud_rate       <= baud_rate;
    in_ch.oversample_by_8 <= over8;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Random word mix. Nearly half the words aim at a chosen divider so results land in range;
  // the rest are raw full-width values, tiny operands, zero baud and odd baud widths.
  task automatic random_word(output logic [CLK_W-1:0] clock_hz,
                             output logic [BAUD_W-1:0] baud_rate,
                             output logic over8);
    int          pick;
    int unsigned target;
    int unsigned steps;
    int unsigned b;
    pick  = $urandom_range(0, 99);
    over8 = 1'($urandom_range(0, 1));
    steps = over8 ? 8 : 16;
    if (pick < 45) begin
      clock_hz = CLK_W'($urandom);
      // near the saturation edge now and then
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(3900, 4400)
                                           : $urandom_range(1, 4095);
      b = clock_hz / (steps * target) + $urandom_range(0, 2);
      if (b == 0) b = 1;
      baud_rate = BAUD_W'(b);
    end else if (pick < 65) begin
      clock_hz  = CLK_W'($urandom);
      baud_rate = BAUD_W'($urandom);
    end else if (pick < 80) begin
      clock_hz  = CLK_W'($urandom_range(0, 5000));
      baud_rate = BAUD_W'($urandom_range(1, 300));
    end else if (pick < 85) begin
      clock_hz  = CLK_W'($urandom);
      baud_rate = '0;
    end else begin
      clock_hz  = CLK_W'($urandom);
      baud_rate = BAUD_W'($urandom & ((32'd1 << $urandom_range(1, BAUD_W)) - 32'd1));
    end
  endtask

  // Result side: steady ready, random ready (high three times in four), or occasional long stalls.
  initial begin
    rx_mode_t rx_mode;
    int       phase_left;
    int       stall_left;
    rx_mode    = RX_STEADY;
    phase_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(16, 200);
      end
      phase_left--;
      case (rx_mode)
        RX_STEADY: begin
          out_ch.ready <= 1'b1;
        end
        RX_CHOPPY: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog: any handshake on either channel resets the idle count.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CLK_W-1:0]  c;
    logic [BAUD_W-1:0] b;
    logic              o;
    int                sent;
    int                burst;
    in_ch.valid           <= 1'b0;
    in_ch.clock_hz        <= '0;
    in_ch.baud_rate       <= '0;
    in_ch.oversample_by_8 <= 1'b0;
    rst_n                 <= 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words
    send_word('0, '0, 1'b0);                       // zero baud and zero clock
    send_word('1, '0, 1'b1);                       // zero baud, full clock
    send_word('0, 24'd115200, 1'b0);               // zero clock gives zero divider
    send_word('0, '1, 1'b1);
    send_word(28'd84000000, 24'd115200, 1'b0);     // typical 16x
    send_word(28'd84000000, 24'd115200, 1'b1);     // typical 8x
    send_word(28'd95, 24'd3, 1'b0);                // fraction carries into mantissa, 16x
    send_word(28'd47, 24'd3, 1'b1);                // fraction carries into mantissa, 8x
    send_word(28'd65520, 24'd1, 1'b0);             // mantissa exactly 4095
    send_word(28'd65535, 24'd1, 1'b0);             // 4095 with top fraction
    send_word(28'd65536, 24'd1, 1'b0);             // one past: saturates
    send_word(28'd196607, 24'd3, 1'b0);            // carry pushes mantissa over the top
    send_word('1, 24'd1, 1'b0);                    // largest 16x divider, saturated
    send_word('1, 24'd1, 1'b1);
    send_word('1, '1, 1'b0);                       // full clock over full baud
    send_word('1, '1, 1'b1);
    send_word(28'd1, '1, 1'b0);                    // divider rounds to zero
    send_word(28'd16, 24'd1, 1'b0);                // divider exactly one
    send_word(28'd8, 24'd1, 1'b1);
    send_word(28'h5555555, 24'hAAAAAA, 1'b1);      // alternating bit patterns
    send_word(28'hAAAAAAA, 24'h555555, 1'b0);
    idle_cycles($urandom_range(1, 10));

    // Random words in bursts; a long burst now and then keeps valid high throughout
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
      repeat (burst) begin
        random_word(c, b, o);
        send_word(c, b, o);
        sent++;
      end
      idle_cycles($urandom_range(0, 12));
    end
    idle_cycles(1);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
